### rtl/fbes_pkg.sv
// ----------------------------------------------------------------------------
// fbes_pkg
// Shared widths, constants and record types for the fractional branch edge
// select block.
// ----------------------------------------------------------------------------
package fbes_pkg;

  localparam int MAX_SUPPORT     = 1024;
  localparam int ADDR_BITS       = $clog2(MAX_SUPPORT);
  localparam int COUNT_BITS      = $clog2(MAX_SUPPORT + 1);
  localparam int EDGE_INDEX_BITS = 16;
  localparam int WEIGHT_BITS     = 17;
  localparam int LENGTH_BITS     = 32;
  localparam int BOUND_BITS      = WEIGHT_BITS + 3;

  localparam logic [WEIGHT_BITS-1:0] HALF_Q16 = WEIGHT_BITS'(32768);
  localparam logic [WEIGHT_BITS-1:0] ONE_Q16  = WEIGHT_BITS'(65536);

  localparam logic [WEIGHT_BITS-1:0] TOL_RESET = WEIGHT_BITS'(1);

  // APB register map: word index taken from paddr[2]
  localparam int  PADDR_BITS   = 3;
  localparam logic REG_HALF_TOL = 1'b0;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0]     weight;
    logic [LENGTH_BITS-1:0]     length;
    logic [EDGE_INDEX_BITS-1:0] index;
    logic                       branched;
  } edge_rec_t;

  typedef struct packed {
    logic [EDGE_INDEX_BITS-1:0] chosen_edge;
    logic                       found;
  } result_t;

endpackage

### rtl/fbes_if.sv
// ----------------------------------------------------------------------------
// fbes_if
// Valid/ready channel interfaces for edge beats and result beats.
// ----------------------------------------------------------------------------
interface fbes_edge_if;
  logic        valid;
  logic        ready;
  logic [15:0] edge_index;
  logic [16:0] edge_weight;
  logic [31:0] edge_length;
  logic        already_branched;
  logic        last_edge;

  modport source (output valid, edge_index, edge_weight, edge_length,
                  already_branched, last_edge, input ready);
  modport sink   (input valid, edge_index, edge_weight, edge_length,
                  already_branched, last_edge, output ready);
endinterface

interface fbes_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] chosen_edge;
  logic        found;

  modport source (output valid, chosen_edge, found, input ready);
  modport sink   (input valid, chosen_edge, found, output ready);
endinterface

### rtl/fbes_edge_store.sv
// ----------------------------------------------------------------------------
// fbes_edge_store
// Single-port-write, single-port-read edge record memory, registered read.
// ----------------------------------------------------------------------------
module fbes_edge_store (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [fbes_pkg::ADDR_BITS-1:0] wr_addr,
  input  fbes_pkg::edge_rec_t            wr_data,
  input  logic                           rd_en,
  input  logic [fbes_pkg::ADDR_BITS-1:0] rd_addr,
  output fbes_pkg::edge_rec_t            rd_data
);

  fbes_pkg::edge_rec_t mem [fbes_pkg::MAX_SUPPORT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/fbes_ctrl.sv
// ----------------------------------------------------------------------------
// fbes_ctrl
// Load sequencer with running half-point fold, then a scan over the store
// through one shared window compare and longest-length unit.
// ----------------------------------------------------------------------------
module fbes_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fbes_pkg::WEIGHT_BITS-1:0]    half_tolerance,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fbes_pkg::edge_rec_t                 in_rec,
  input  logic                                in_last,
  input  logic                                out_free,
  output logic                                res_load,
  output fbes_pkg::result_t                   res
);

  typedef enum logic [1:0] {ST_LOAD, ST_PREP, ST_SCAN, ST_DONE} state_t;

  state_t state;

  logic [fbes_pkg::COUNT_BITS-1:0]      count;
  logic [fbes_pkg::COUNT_BITS-1:0]      ptr;
  logic [fbes_pkg::WEIGHT_BITS-1:0]     low;
  logic [fbes_pkg::WEIGHT_BITS-1:0]     up;
  logic [fbes_pkg::BOUND_BITS-1:0]      lo3;
  logic [fbes_pkg::BOUND_BITS-1:0]      hi4;
  logic [fbes_pkg::LENGTH_BITS-1:0]     best_len;
  logic [fbes_pkg::EDGE_INDEX_BITS-1:0] best_idx;
  logic                                 best_found;
  logic                                 rd_valid;

  logic                                 accept;
  logic                                 room;
  logic                                 wr_en;
  logic                                 rd_en;
  fbes_pkg::edge_rec_t                  rd_data;
  logic [fbes_pkg::WEIGHT_BITS-1:0]     half_gap;
  logic [fbes_pkg::WEIGHT_BITS-1:0]     low_next;
  logic [fbes_pkg::WEIGHT_BITS-1:0]     up_next;
  logic [fbes_pkg::BOUND_BITS-1:0]      w4;
  logic                                 in_window;

  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign room     = (count < fbes_pkg::COUNT_BITS'(fbes_pkg::MAX_SUPPORT));
  assign wr_en    = accept && room;
  assign rd_en    = (state == ST_SCAN) && (ptr < count);
  assign res_load = (state == ST_DONE) && out_free;

  assign res.chosen_edge = best_idx;
  assign res.found       = best_found;

  fbes_edge_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[fbes_pkg::ADDR_BITS-1:0]),
    .wr_data (in_rec),
    .rd_en   (rd_en),
    .rd_addr (ptr[fbes_pkg::ADDR_BITS-1:0]),
    .rd_data (rd_data)
  );

  // fold of one unbranched weight into the two extremes
  always_comb begin
    half_gap = (in_rec.weight >= fbes_pkg::HALF_Q16) ? (in_rec.weight - fbes_pkg::HALF_Q16)
                                                      : (fbes_pkg::HALF_Q16 - in_rec.weight);
    low_next = low;
    up_next  = up;
    if (half_gap < half_tolerance) begin
      low_next = fbes_pkg::HALF_Q16;
      up_next  = fbes_pkg::HALF_Q16;
    end else if (in_rec.weight < fbes_pkg::HALF_Q16) begin
      if (in_rec.weight > low) low_next = in_rec.weight;
    end else if (in_rec.weight > fbes_pkg::HALF_Q16) begin
      if (in_rec.weight < up) up_next = in_rec.weight;
    end
  end

  // window test: 4*w against 3*low and 3*up + 1.0
  assign w4        = {1'b0, rd_data.weight, 2'b00};
  assign in_window = !rd_data.branched && !(w4 < lo3) && !(w4 > hi4);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      ptr        <= '0;
      low        <= '0;
      up         <= fbes_pkg::ONE_Q16;
      rd_valid   <= 1'b0;
      best_found <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      case (state)
        ST_LOAD: begin
          if (wr_en) begin
            count <= count + 1'b1;
            if (!in_rec.branched) begin
              low <= low_next;
              up  <= up_next;
            end
          end
          if (accept && in_last) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          lo3        <= {3'b000, low} + {2'b00, low, 1'b0};
          hi4        <= {3'b000, up} + {2'b00, up, 1'b0} + {3'b000, fbes_pkg::ONE_Q16};
          ptr        <= '0;
          best_len   <= '0;
          best_idx   <= '0;
          best_found <= 1'b0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_en) begin
            ptr <= ptr + 1'b1;
          end else if (!rd_valid) begin
            state <= ST_DONE;
          end
          // strict greater keeps the first of equal lengths
          if (rd_valid && in_window && (rd_data.length > best_len)) begin
            best_len   <= rd_data.length;
            best_idx   <= rd_data.index;
            best_found <= 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count <= '0;
            low   <= '0;
            up    <= fbes_pkg::ONE_Q16;
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

### rtl/fractional_branch_edge_select.sv
// ----------------------------------------------------------------------------
// fractional_branch_edge_select
// Loads a set of support edges, then picks the longest unbranched edge
// whose weight lies in the window around the closest weights to one half.
// ----------------------------------------------------------------------------
//  channel     dir  beat contents
//  edge_in     in   edge_index, edge_weight, edge_length, already_branched,
//                   last_edge
//  result_out  out  chosen_edge, found (one beat per set)
//  apb         in   half_tolerance at word 0
//
//  Loading runs one beat per cycle. After the beat marked last, edge_in is
//  not ready while the block forms the window bounds, reads the N stored
//  edges (up to 1024) through the single read port of the edge memory,
//  drains the last read and loads the result register. The result is
//  valid right after that.
//  The result sits in an output register, so the next set loads while it
//  waits. A stalled result holds the block only if the next set finishes too.
//  Synchronous reset clears the set and sets half_tolerance to 1.
// ----------------------------------------------------------------------------
module fractional_branch_edge_select (
  input  logic                            clk,
  input  logic                            rst,
  fbes_edge_if.sink                       edge_in,
  fbes_result_if.source                   result_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbes_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [fbes_pkg::WEIGHT_BITS-1:0] half_tolerance;
  logic                             cfg_wr;
  fbes_pkg::edge_rec_t              in_rec;
  fbes_pkg::result_t                res;
  logic                             res_load;
  logic                             out_free;
  logic                             out_valid;
  fbes_pkg::result_t                out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == fbes_pkg::REG_HALF_TOL);
  assign prdata = (paddr[2] == fbes_pkg::REG_HALF_TOL) ? {15'd0, half_tolerance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_tolerance <= fbes_pkg::TOL_RESET;
    end else if (cfg_wr) begin
      half_tolerance <= pwdata[fbes_pkg::WEIGHT_BITS-1:0];
    end
  end

  assign in_rec.weight   = edge_in.edge_weight;
  assign in_rec.length   = edge_in.edge_length;
  assign in_rec.index    = edge_in.edge_index[fbes_pkg::EDGE_INDEX_BITS-1:0];
  assign in_rec.branched = edge_in.already_branched;

  assign out_free = !out_valid || result_out.ready;

  fbes_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .half_tolerance (half_tolerance),
    .in_valid       (edge_in.valid),
    .in_ready       (edge_in.ready),
    .in_rec         (in_rec),
    .in_last        (edge_in.last_edge),
    .out_free       (out_free),
    .res_load       (res_load),
    .res            (res)
  );

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.chosen_edge = out_data.chosen_edge;
  assign result_out.found       = out_data.found;

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.found) |-> (result_out.chosen_edge == '0))
    else $error("result without a found edge carries a nonzero index");

  a_last_closes_set: assert property (@(posedge clk) disable iff (rst)
    (edge_in.valid && edge_in.ready && edge_in.last_edge) |=> !edge_in.ready)
    else $error("edge input still ready after the last beat of a set");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || result_out.ready))
    else $error("result loaded over a pending beat");

endmodule
